// ----- rtl/shape_overlap_test_2d_defines.svh -----
`ifndef SHAPE_OVERLAP_TEST_2D_DEFINES_SVH
`define SHAPE_OVERLAP_TEST_2D_DEFINES_SVH

// Concurrent checks sampled on clk and held off while arst_n is low.

// The antecedent implies the consequent in the same cycle.
`define SOT_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The antecedent implies the consequent a fixed number of cycles later.
`define SOT_ASSERT_DELAY(lbl, ante, n, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

// ----- rtl/sot_pkg.sv -----
`timescale 1ns / 1ps

package sot_pkg;

	// Configuration port shape.
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = 32;
	localparam int LAYER_WIDTH     = 5;
	localparam int MASK_WIDTH      = 32;

	// Register indexes.
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_OWN_IS_CIRCLE = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_OWN_WIDTH     = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_OWN_HEIGHT    = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_OWN_RADIUS    = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_OWN_OFFSET_X  = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_OWN_OFFSET_Y  = 3'd5;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_OWN_ENABLED   = 3'd6;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_LAYER_MASK    = 3'd7;

	// Which test a request needs. Every test involving a circle runs as a
	// circle against a box, where two circles use a box of zero size.
	typedef enum logic {
		KIND_BOXES = 1'b0,
		KIND_ROUND = 1'b1
	} kind_t;

	typedef struct packed {
		logic  active;
		kind_t kind;
	} item_ctl_t;

endpackage

// ----- rtl/shape_overlap_test_2d.sv -----
// A request taken at a clock edge goes through the queue, stages 1 to 3 and
// the result register, and shows its hit bit with done high for exactly one cycle.
// Throughput: one request per clock; the result side cannot stall, so busy
// stays low in use.
// Reset: arst_n low clears all control state and loads the register reset
// values at once; no clearing pass is needed.
`timescale 1ns / 1ps

`include "shape_overlap_test_2d_defines.svh"

module shape_overlap_test_2d #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [COORD_WIDTH-1:0]          own_x,
	input  logic signed [COORD_WIDTH-1:0]          own_y,
	input  logic signed [COORD_WIDTH-1:0]          peer_x,
	input  logic signed [COORD_WIDTH-1:0]          peer_y,
	input  logic                                   peer_is_circle,
	input  logic [COORD_WIDTH-1:0]                 peer_width,
	input  logic [COORD_WIDTH-1:0]                 peer_height,
	input  logic [COORD_WIDTH-1:0]                 peer_radius,
	input  logic signed [COORD_WIDTH-1:0]          peer_offset_x,
	input  logic signed [COORD_WIDTH-1:0]          peer_offset_y,
	input  logic                                   peer_enabled,
	input  logic [sot_pkg::LAYER_WIDTH-1:0]        peer_layer,
	input  logic                                   cfg_we,
	input  logic [sot_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [sot_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
	output logic                                   done,
	output logic                                   hit
);

	localparam int W       = COORD_WIDTH;
	localparam int PAY_W   = 9 * W + 5;
	localparam int CTL_W   = $bits(sot_pkg::item_ctl_t);
	localparam int ENTRY_W = CTL_W + PAY_W;
	// Edges from the one that accepts a request to the one that takes its
	// result.
	localparam int LATENCY = 5;

	// The local collider's configuration. Every write lands in the same
	// cycle; narrower registers keep only the low bits of the write data.
	logic                              own_is_circle_q;
	logic [W-1:0]                      own_width_q;
	logic [W-1:0]                      own_height_q;
	logic [W-1:0]                      own_radius_q;
	logic signed [W-1:0]               own_offset_x_q;
	logic signed [W-1:0]               own_offset_y_q;
	logic                              own_enabled_q;
	logic [sot_pkg::MASK_WIDTH-1:0]    layer_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_is_circle_q <= 1'b0;
			own_width_q     <= '0;
			own_height_q    <= '0;
			own_radius_q    <= '0;
			own_offset_x_q  <= '0;
			own_offset_y_q  <= '0;
			own_enabled_q   <= 1'b1;
			layer_mask_q    <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sot_pkg::REG_OWN_IS_CIRCLE: own_is_circle_q <= cfg_data[0];
				sot_pkg::REG_OWN_WIDTH:     own_width_q     <= cfg_data[W-1:0];
				sot_pkg::REG_OWN_HEIGHT:    own_height_q    <= cfg_data[W-1:0];
				sot_pkg::REG_OWN_RADIUS:    own_radius_q    <= cfg_data[W-1:0];
				sot_pkg::REG_OWN_OFFSET_X:  own_offset_x_q  <= cfg_data[W-1:0];
				sot_pkg::REG_OWN_OFFSET_Y:  own_offset_y_q  <= cfg_data[W-1:0];
				sot_pkg::REG_OWN_ENABLED:   own_enabled_q   <= cfg_data[0];
				sot_pkg::REG_LAYER_MASK:    layer_mask_q    <= cfg_data;
			endcase
		end
	end

	// The front end gates each request on the enable bits and the layer mask,
	// picks which test it needs and lines up the operands so that every test
	// involving a circle has the circle on side A.
	logic                  push;
	logic                  queue_full;
	logic                  queue_empty;
	sot_pkg::item_ctl_t    front_ctl;
	logic [PAY_W-1:0]      front_payload;
	logic [ENTRY_W-1:0]    head;
	sot_pkg::item_ctl_t    head_ctl;
	logic [PAY_W-1:0]      head_payload;

	sot_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.start         (start),
		.busy          (busy),
		.own_x         (own_x),
		.own_y         (own_y),
		.peer_x        (peer_x),
		.peer_y        (peer_y),
		.peer_is_circle(peer_is_circle),
		.peer_width    (peer_width),
		.peer_height   (peer_height),
		.peer_radius   (peer_radius),
		.peer_offset_x (peer_offset_x),
		.peer_offset_y (peer_offset_y),
		.peer_enabled  (peer_enabled),
		.peer_layer    (peer_layer),
		.own_is_circle (own_is_circle_q),
		.own_width     (own_width_q),
		.own_height    (own_height_q),
		.own_radius    (own_radius_q),
		.own_offset_x  (own_offset_x_q),
		.own_offset_y  (own_offset_y_q),
		.own_enabled   (own_enabled_q),
		.layer_mask    (layer_mask_q),
		.queue_full    (queue_full),
		.push          (push),
		.ctl           (front_ctl),
		.payload       (front_payload)
	);

	// A two-entry queue parts the front end from the arithmetic pipeline.
	// The pipeline drains the head every cycle, so the queue never fills in
	// practice and a request can enter on every clock.
	sot_queue #(
		.WIDTH(ENTRY_W)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   ({front_ctl, front_payload}),
		.pop   (!queue_empty),
		.dout  (head),
		.empty (queue_empty),
		.full  (queue_full)
	);

	assign head_ctl     = head[ENTRY_W-1:PAY_W];
	assign head_payload = head[PAY_W-1:0];

	// The back end is a four-stage pipeline: bounds, per-axis distances,
	// exact squares, then the compare that loads the result register.
	sot_back #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!queue_empty),
		.in_ctl    (head_ctl),
		.in_payload(head_payload),
		.done      (done),
		.hit       (hit)
	);

	// Every accepted request comes out after a fixed latency.
	`SOT_ASSERT_DELAY(a_fixed_latency, start && !busy, LATENCY, done, "request result missing")
	// No result without a request accepted the same number of cycles before.
	`SOT_ASSERT_IMPLY(a_no_spurious, done, $past(start && !busy, LATENCY), "spurious result")
	// A disabled peer never reports a hit.
	`SOT_ASSERT_DELAY(a_peer_disabled, start && !busy && !peer_enabled, LATENCY, !hit, "hit on disabled peer")

endmodule

// ----- rtl/sot_front.sv -----
`timescale 1ns / 1ps

module sot_front #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [COORD_WIDTH-1:0]        own_x,
	input  logic signed [COORD_WIDTH-1:0]        own_y,
	input  logic signed [COORD_WIDTH-1:0]        peer_x,
	input  logic signed [COORD_WIDTH-1:0]        peer_y,
	input  logic                                 peer_is_circle,
	input  logic [COORD_WIDTH-1:0]               peer_width,
	input  logic [COORD_WIDTH-1:0]               peer_height,
	input  logic [COORD_WIDTH-1:0]               peer_radius,
	input  logic signed [COORD_WIDTH-1:0]        peer_offset_x,
	input  logic signed [COORD_WIDTH-1:0]        peer_offset_y,
	input  logic                                 peer_enabled,
	input  logic [sot_pkg::LAYER_WIDTH-1:0]      peer_layer,
	input  logic                                 own_is_circle,
	input  logic [COORD_WIDTH-1:0]               own_width,
	input  logic [COORD_WIDTH-1:0]               own_height,
	input  logic [COORD_WIDTH-1:0]               own_radius,
	input  logic signed [COORD_WIDTH-1:0]        own_offset_x,
	input  logic signed [COORD_WIDTH-1:0]        own_offset_y,
	input  logic                                 own_enabled,
	input  logic [sot_pkg::MASK_WIDTH-1:0]       layer_mask,
	input  logic                                 queue_full,
	output logic                                 push,
	output sot_pkg::item_ctl_t                   ctl,
	output logic [9*COORD_WIDTH+4:0]             payload
);

	localparam int W = COORD_WIDTH;

	logic signed [W:0] x1, y1, x2, y2;
	logic signed [W:0] pa_x, pa_y, pb_x, pb_y;
	logic [W-1:0]      sa_w, sa_h, sb_w, sb_h;
	logic [W:0]        rad;
	logic              boxes;
	logic              own_is_a;

	assign busy = queue_full;
	assign push = start && !queue_full;

	// Centres with their offsets, one bit wider so the sum is exact.
	assign x1 = {own_x[W-1], own_x} + {own_offset_x[W-1], own_offset_x};
	assign y1 = {own_y[W-1], own_y} + {own_offset_y[W-1], own_offset_y};
	assign x2 = {peer_x[W-1], peer_x} + {peer_offset_x[W-1], peer_offset_x};
	assign y2 = {peer_y[W-1], peer_y} + {peer_offset_y[W-1], peer_offset_y};

	assign boxes    = !own_is_circle && !peer_is_circle;
	// Side A is the circle in a mixed pair, otherwise the local collider.
	assign own_is_a = !(peer_is_circle && !own_is_circle);

	always_comb begin
		pa_x = own_is_a ? x1 : x2;
		pa_y = own_is_a ? y1 : y2;
		pb_x = own_is_a ? x2 : x1;
		pb_y = own_is_a ? y2 : y1;
		sa_w = '0;
		sa_h = '0;
		sb_w = '0;
		sb_h = '0;
		rad  = '0;
		if (boxes) begin
			sa_w = own_width;
			sa_h = own_height;
			sb_w = peer_width;
			sb_h = peer_height;
		end else if (own_is_circle && peer_is_circle) begin
			rad = {1'b0, own_radius} + {1'b0, peer_radius};
		end else if (own_is_circle) begin
			sb_w = peer_width;
			sb_h = peer_height;
			rad  = {1'b0, own_radius};
		end else begin
			sb_w = own_width;
			sb_h = own_height;
			rad  = {1'b0, peer_radius};
		end
	end

	assign ctl.active = own_enabled && peer_enabled && layer_mask[peer_layer];
	assign ctl.kind   = boxes ? sot_pkg::KIND_BOXES : sot_pkg::KIND_ROUND;

	assign payload = {pa_x, pa_y, pb_x, pb_y, sa_w, sa_h, sb_w, sb_h, rad};

endmodule

// ----- rtl/sot_queue.sv -----
`timescale 1ns / 1ps

module sot_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty,
	output logic             full
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (count_q == 2'd0);
	assign full    = (count_q == 2'd2);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ----- rtl/sot_back.sv -----
`timescale 1ns / 1ps

module sot_back #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  sot_pkg::item_ctl_t       in_ctl,
	input  logic [9*COORD_WIDTH+4:0] in_payload,
	output logic                     done,
	output logic                     hit
);

	localparam int W     = COORD_WIDTH;
	localparam int MAG_W = W + 3;
	localparam int SQ_W  = 2 * MAG_W;
	localparam int SUM_W = SQ_W + 1;

	logic signed [W:0] pa_x, pa_y, pb_x, pb_y;
	logic [W-1:0]      sa_w, sa_h, sb_w, sb_h;
	logic [W:0]        rad;

	assign {pa_x, pa_y, pb_x, pb_y, sa_w, sa_h, sb_w, sb_h, rad} = in_payload;

	// Stage 1: doubled centres and box bounds in one extra fraction bit.
	logic signed [W+1:0]    a2_x, a2_y, b2_x, b2_y;
	logic                   valid_s1;
	sot_pkg::item_ctl_t     ctl_s1;
	logic signed [MAG_W-1:0] alo_x_s1, ahi_x_s1, alo_y_s1, ahi_y_s1;
	logic signed [MAG_W-1:0] blo_x_s1, bhi_x_s1, blo_y_s1, bhi_y_s1;
	logic [W+1:0]           rad2_s1;

	assign a2_x = {pa_x, 1'b0};
	assign a2_y = {pa_y, 1'b0};
	assign b2_x = {pb_x, 1'b0};
	assign b2_y = {pb_y, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1   <= in_ctl;
		alo_x_s1 <= {a2_x[W+1], a2_x} - $signed({3'b000, sa_w});
		ahi_x_s1 <= {a2_x[W+1], a2_x} + $signed({3'b000, sa_w});
		alo_y_s1 <= {a2_y[W+1], a2_y} - $signed({3'b000, sa_h});
		ahi_y_s1 <= {a2_y[W+1], a2_y} + $signed({3'b000, sa_h});
		blo_x_s1 <= {b2_x[W+1], b2_x} - $signed({3'b000, sb_w});
		bhi_x_s1 <= {b2_x[W+1], b2_x} + $signed({3'b000, sb_w});
		blo_y_s1 <= {b2_y[W+1], b2_y} - $signed({3'b000, sb_h});
		bhi_y_s1 <= {b2_y[W+1], b2_y} + $signed({3'b000, sb_h});
		rad2_s1  <= {rad, 1'b0};
	end

	// Stage 2: box overlap, and the distance from the circle centre to the
	// nearest point of the box on each axis. For a circle side both bounds
	// of side A equal its doubled centre.
	logic                   valid_s2;
	sot_pkg::item_ctl_t     ctl_s2;
	logic                   bb_hit_s2;
	logic [MAG_W-1:0]       mx_s2, my_s2;
	logic [W+1:0]           rad2_s2;
	logic [MAG_W-1:0]       mx, my;
	logic [MAG_W-1:0]       dx_hi, dx_lo, dy_hi, dy_lo;

	assign dx_hi = alo_x_s1 - bhi_x_s1;
	assign dx_lo = blo_x_s1 - alo_x_s1;
	assign dy_hi = alo_y_s1 - bhi_y_s1;
	assign dy_lo = blo_y_s1 - alo_y_s1;

	always_comb begin
		if (alo_x_s1 > bhi_x_s1) begin
			mx = dx_hi;
		end else if (alo_x_s1 < blo_x_s1) begin
			mx = dx_lo;
		end else begin
			mx = '0;
		end
		if (alo_y_s1 > bhi_y_s1) begin
			my = dy_hi;
		end else if (alo_y_s1 < blo_y_s1) begin
			my = dy_lo;
		end else begin
			my = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s2    <= ctl_s1;
		bb_hit_s2 <= !((ahi_x_s1 < blo_x_s1) || (alo_x_s1 > bhi_x_s1) ||
			(ahi_y_s1 < blo_y_s1) || (alo_y_s1 > bhi_y_s1));
		mx_s2     <= mx;
		my_s2     <= my;
		rad2_s2   <= rad2_s1;
	end

	// Stage 3: exact squares.
	logic                   valid_s3;
	sot_pkg::item_ctl_t     ctl_s3;
	logic                   bb_hit_s3;
	logic [SQ_W-1:0]        sqx_s3, sqy_s3, sqr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s3    <= ctl_s2;
		bb_hit_s3 <= bb_hit_s2;
		sqx_s3    <= SQ_W'(mx_s2) * SQ_W'(mx_s2);
		sqy_s3    <= SQ_W'(my_s2) * SQ_W'(my_s2);
		sqr_s3    <= SQ_W'(rad2_s2) * SQ_W'(rad2_s2);
	end

	// Stage 4: distance compare and the result register.
	logic             done_s4;
	logic             hit_s4;
	logic [SUM_W-1:0] dist_sq;
	logic             round_hit;

	assign dist_sq   = SUM_W'(sqx_s3) + SUM_W'(sqy_s3);
	assign round_hit = (dist_sq <= SUM_W'(sqr_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s4 <= 1'b0;
		end else begin
			done_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		hit_s4 <= ctl_s3.active &&
			((ctl_s3.kind == sot_pkg::KIND_BOXES) ? bb_hit_s3 : round_hit);
	end

	assign done = done_s4;
	assign hit  = hit_s4;

endmodule
